[hw/rtl/spq_pkg.sv]
// Shared types and constants for the sorted priority queue.
`default_nettype none

package spq_pkg;

    // Command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_POP    = 1'b1;

    // Entry status value that allows an insert
    localparam logic IS_WAITING = 1'b1;

    // Result status codes
    typedef enum logic [2:0] {
        ST_INSERTED    = 3'd0,
        ST_NOT_WAITING = 3'd1,
        ST_DUPLICATE   = 3'd2,
        ST_FULL        = 3'd3,
        ST_POPPED      = 3'd4,
        ST_EMPTY       = 3'd5
    } t_status;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_SCAN,
        S_SHIFT
    } t_state;

    // One stored entry; priority and time together form the sort key
    typedef struct packed {
        logic [2:0]  prio;
        logic [31:0] rtime;
        logic [15:0] id;
        logic [31:0] tag;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

`default_nettype wire

[hw/rtl/spq_ram.sv]
// Generic simple dual-port RAM with registered read.
`default_nettype none

module spq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 2) ? $clog2(DEPTH) : 1
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [AW-1:0]            i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [AW-1:0]            i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[hw/rtl/sorted_priority_queue.sv]
// Top level of the sorted priority queue: command controller around the entry RAM.
`default_nettype none

// Bounded priority queue kept sorted in one RAM used as a ring (head pointer plus count):
// ascending priority, then earlier registration time, equal keys in arrival order.
// A command is taken when start is high and busy is low; its single result word appears
// on the o_ ports for exactly one cycle, flagged by o_strobe, and cannot be stalled.
// Sequence per command: pop of an empty queue and insert of a non-waiting entry answer
// straight from idle; a pop reads the head entry from the RAM; any other insert first
// scans every queued entry, one read per cycle, for the duplicate check and insert point,
// and a duplicate or a full queue is answered at the end of the scan; a stored insert
// then moves the entries behind insert point p down one slot and writes the new one.
// The RAM has a single read port. The next command may be given in the cycle that
// shows the strobe. No clearing pass is needed after reset.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_cmd,
    input  wire logic [15:0] i_visit_id,
    input  wire logic [2:0]  i_priority_req,
    input  wire logic [31:0] i_reg_time,
    input  wire logic        i_is_waiting,
    input  wire logic [31:0] i_record_tag,
    output logic             o_strobe,
    output logic [2:0]       o_status,
    output logic [15:0]      o_out_id,
    output logic [2:0]       o_out_priority,
    output logic [31:0]      o_out_time,
    output logic [31:0]      o_out_tag,
    output logic [4:0]       o_count,
    output logic             o_is_empty
);

    localparam int IW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = IW + 1;

    // Ring pointer helpers
    function automatic logic [IW-1:0] f_next(input logic [IW-1:0] p);
        f_next = (p == IW'(CAPACITY - 1)) ? '0 : IW'(p + 1'b1);
    endfunction

    function automatic logic [IW-1:0] f_prev(input logic [IW-1:0] p);
        f_prev = (p == '0) ? IW'(CAPACITY - 1) : IW'(p - 1'b1);
    endfunction

    // Control registers
    t_state        r_state,   n_state;
    logic [CW-1:0] r_count,   n_count;
    logic [IW-1:0] r_head,    n_head;
    logic          r_res_vld, n_res_vld;

    // Working registers
    t_entry        r_new,     n_new;
    logic [IW-1:0] r_rd_ptr,  n_rd_ptr;
    logic [IW-1:0] r_wr_ptr,  n_wr_ptr;
    logic [CW-1:0] r_issued,  n_issued;
    logic [CW-1:0] r_pos,     n_pos;
    logic [CW-1:0] r_steps,   n_steps;
    logic          r_rd_vld,  n_rd_vld;
    logic          r_dup,     n_dup;

    // Result registers
    t_status       r_status,  n_status;
    t_entry        r_out,     n_out;

    // RAM port
    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    t_entry             ram_wdata;
    logic               ram_re;
    logic [IW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    t_entry             rd_entry;

    // Tail slot: head + count, wrapped once
    logic [SW-1:0] tail_sum;
    logic [IW-1:0] tail;

    assign rd_entry = t_entry'(ram_rdata);
    assign tail_sum = SW'(r_head) + SW'(r_count);
    assign tail     = (tail_sum >= SW'(CAPACITY)) ? IW'(tail_sum - SW'(CAPACITY))
                                                  : IW'(tail_sum);

    spq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Next state, RAM access and result
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_head    = r_head;
        n_res_vld = 1'b0;
        n_new     = r_new;
        n_rd_ptr  = r_rd_ptr;
        n_wr_ptr  = r_wr_ptr;
        n_issued  = r_issued;
        n_pos     = r_pos;
        n_steps   = r_steps;
        n_rd_vld  = 1'b0;
        n_dup     = r_dup;
        n_status  = r_status;
        n_out     = r_out;
        ram_we    = 1'b0;
        ram_waddr = r_wr_ptr;
        ram_wdata = rd_entry;
        ram_re    = 1'b0;
        ram_raddr = r_rd_ptr;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_new = '{prio: i_priority_req, rtime: i_reg_time,
                              id: i_visit_id, tag: i_record_tag};
                    if (i_cmd == CMD_POP) begin
                        if (r_count == '0) begin
                            n_res_vld = 1'b1;
                            n_status  = ST_EMPTY;
                            n_out     = '0;
                        end else begin
                            ram_re    = 1'b1;
                            ram_raddr = r_head;
                            n_state   = S_POP;
                        end
                    end else if (i_is_waiting != IS_WAITING) begin
                        n_res_vld = 1'b1;
                        n_status  = ST_NOT_WAITING;
                        n_out     = '0;
                    end else begin
                        n_state  = S_SCAN;
                        n_rd_ptr = r_head;
                        n_issued = '0;
                        n_pos    = '0;
                        n_dup    = 1'b0;
                    end
                end
            end

            // Head word is back from the RAM
            S_POP: begin
                n_res_vld = 1'b1;
                n_status  = ST_POPPED;
                n_out     = rd_entry;
                n_head    = f_next(r_head);
                n_count   = CW'(r_count - 1'b1);
                n_state   = S_IDLE;
            end

            // Read every queued entry: duplicate id check and insert point
            S_SCAN: begin
                if (r_issued != r_count) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_rd_ptr;
                    n_rd_ptr  = f_next(r_rd_ptr);
                    n_issued  = CW'(r_issued + 1'b1);
                    n_rd_vld  = 1'b1;
                end
                if (r_rd_vld) begin
                    if (rd_entry.id == r_new.id) begin
                        n_dup = 1'b1;
                    end
                    if ({rd_entry.prio, rd_entry.rtime} <= {r_new.prio, r_new.rtime}) begin
                        n_pos = CW'(r_pos + 1'b1);
                    end
                end
                if ((r_issued == r_count) && !r_rd_vld) begin
                    if (r_dup) begin
                        n_res_vld = 1'b1;
                        n_status  = ST_DUPLICATE;
                        n_out     = '0;
                        n_state   = S_IDLE;
                    end else if (r_count == CW'(CAPACITY)) begin
                        n_res_vld = 1'b1;
                        n_status  = ST_FULL;
                        n_out     = '0;
                        n_state   = S_IDLE;
                    end else begin
                        n_wr_ptr = tail;
                        n_rd_ptr = f_prev(tail);
                        n_steps  = CW'(r_count - r_pos);
                        n_state  = S_SHIFT;
                    end
                end
            end

            // Move entries behind the insert point down one slot, then write the new one
            S_SHIFT: begin
                if (r_steps != '0) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_rd_ptr;
                    n_rd_ptr  = f_prev(r_rd_ptr);
                    n_steps   = CW'(r_steps - 1'b1);
                    n_rd_vld  = 1'b1;
                end
                if (r_rd_vld) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_wr_ptr;
                    ram_wdata = rd_entry;
                    n_wr_ptr  = f_prev(r_wr_ptr);
                end
                if ((r_steps == '0) && !r_rd_vld) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_wr_ptr;
                    ram_wdata = r_new;
                    n_count   = CW'(r_count + 1'b1);
                    n_res_vld = 1'b1;
                    n_status  = ST_INSERTED;
                    n_out     = '0;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_head    <= '0;
            r_res_vld <= 1'b0;
            r_rd_vld  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_head    <= n_head;
            r_res_vld <= n_res_vld;
            r_rd_vld  <= n_rd_vld;
        end
    end

    // Working and result words
    always_ff @(posedge i_clk) begin
        r_new    <= n_new;
        r_rd_ptr <= n_rd_ptr;
        r_wr_ptr <= n_wr_ptr;
        r_issued <= n_issued;
        r_pos    <= n_pos;
        r_steps  <= n_steps;
        r_dup    <= n_dup;
        r_status <= n_status;
        r_out    <= n_out;
    end

    // Outputs
    assign busy           = (r_state != S_IDLE);
    assign o_strobe       = r_res_vld;
    assign o_status       = r_status;
    assign o_out_id       = r_out.id;
    assign o_out_priority = r_out.prio;
    assign o_out_time     = r_out.rtime;
    assign o_out_tag      = r_out.tag;
    assign o_count        = 5'(r_count);
    assign o_is_empty     = (r_count == '0);

endmodule

`default_nettype wire

[hw/rtl/spq_checker.sv]
// Port-level checker for the sorted priority queue, bound to the top level.
`default_nettype none

module spq_checker
    import spq_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        o_strobe,
    input wire logic [2:0]  o_status,
    input wire logic [15:0] o_out_id,
    input wire logic [2:0]  o_out_priority,
    input wire logic [31:0] o_out_time,
    input wire logic [31:0] o_out_tag,
    input wire logic [4:0]  o_count
);

    // A result word only follows an accepted command or a busy cycle
    a_strobe_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && $past(i_rst_n) |-> $past(busy) || $past(start))
        else $error("result word without a command in progress");

    // Only a successful pop carries entry fields
    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_status != ST_POPPED) |->
            (o_out_id == '0) && (o_out_priority == '0) &&
            (o_out_time == '0) && (o_out_tag == '0))
        else $error("entry fields not zero on a non-pop result");

    // The count moves only together with a result word
    a_count_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$stable(o_count) |-> o_strobe)
        else $error("count changed without a result word");

    // A pop removes exactly one entry
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && o_strobe && (o_status == ST_POPPED) |->
            5'(o_count + 5'd1) == $past(o_count))
        else $error("pop did not lower count by one");

    // A successful insert adds exactly one entry
    a_ins_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && o_strobe && (o_status == ST_INSERTED) |->
            o_count == 5'($past(o_count) + 5'd1))
        else $error("insert did not raise count by one");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_strobe       (o_strobe),
    .o_status       (o_status),
    .o_out_id       (o_out_id),
    .o_out_priority (o_out_priority),
    .o_out_time     (o_out_time),
    .o_out_tag      (o_out_tag),
    .o_count        (o_count)
);

`default_nettype wire
